// File: design/bf3_pkg.sv
// Shared constants, types and the divide-by-nine helper for the 3x3 box filter.
// No dependencies; every other design file except bf3_ram imports this package.
`default_nettype none
package bf3_pkg;

  localparam int MAX_COLS    = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int ROW_W    = 12;
  localparam int COL_W    = 10;
  localparam int ROWS_W   = 13;
  localparam int COLS_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int LINE_W = 2 * SAMPLE_BITS;

  // column sum of three samples, and nine-sample sum plus rounding bias
  localparam int CSUM_W = SAMPLE_BITS + 2;
  localparam int SUM_W  = SAMPLE_BITS + 4;

  localparam logic [ROWS_W-1:0] ROWS_MIN   = ROWS_W'(3);
  localparam logic [ROWS_W-1:0] ROWS_LIMIT = ROWS_W'(4096);
  localparam logic [COLS_W-1:0] COLS_MIN   = COLS_W'(3);
  localparam logic [COLS_W-1:0] COLS_LIMIT =
      COLS_W'((MAX_COLS < 1024) ? MAX_COLS : 1024);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = CFG_IDX_W'(1);

  // floor(x / 9) == floor(x * ceil(2^SHIFT / 9) / 2^SHIFT) for x < 2^SUM_W
  localparam int RECIP_SHIFT = SUM_W + 5;
  localparam int RECIP_W     = RECIP_SHIFT - 2;
  localparam logic [RECIP_W-1:0] RECIP_9 =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd8) / 64'd9);
  localparam int PROD_W = SUM_W + RECIP_W;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic             res;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] avg;
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic                   last;
  } out_item_t;

  function automatic logic [SAMPLE_BITS-1:0] quot_from_prod(input logic [PROD_W-1:0] p);
    quot_from_prod = p[RECIP_SHIFT +: SAMPLE_BITS];
  endfunction

endpackage
`default_nettype wire

// File: design/bf3_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone, no package dependency.
`default_nettype none
module bf3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: design/bf3_window.sv
// 3x3 window: keeps sums of the two previous columns and forms the nine-sample
// sum plus rounding bias, registered. Depends on bf3_pkg.
`default_nettype none
module bf3_window
  import bf3_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire tag_t                   tag_i,
  input  wire logic [SAMPLE_BITS-1:0] top_i,
  input  wire logic [SAMPLE_BITS-1:0] mid_i,
  input  wire logic [SAMPLE_BITS-1:0] bot_i,
  output logic                        valid_o,
  output tag_t                        tag_o,
  output logic      [SUM_W-1:0]       sum_o
);

  logic [CSUM_W-1:0] cs1_q, cs2_q, cur;
  logic [SUM_W-1:0]  sum_d;

  assign cur   = CSUM_W'(top_i) + CSUM_W'(mid_i) + CSUM_W'(bot_i);
  assign sum_d = SUM_W'(cs2_q) + SUM_W'(cs1_q) + SUM_W'(cur) + SUM_W'(4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs1_q   <= '0;
      cs2_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i && tag_i.res;
      if (valid_i) begin
        cs2_q <= cs1_q;
        cs1_q <= cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      tag_o <= tag_i;
      sum_o <= sum_d;
    end
  end

endmodule
`default_nettype wire

// File: design/bf3_divider.sv
// Divide by nine through a reciprocal multiply, one register after the product.
// Depends on bf3_pkg.
`default_nettype none
module bf3_divider
  import bf3_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire tag_t             tag_i,
  input  wire logic [SUM_W-1:0] sum_i,
  output logic                  valid_o,
  output out_item_t             item_o
);

  logic [PROD_W-1:0] prod_q;
  tag_t              tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_q <= PROD_W'(sum_i) * PROD_W'(RECIP_9);
      tag_q  <= tag_i;
    end
  end

  assign item_o.avg  = quot_from_prod(prod_q);
  assign item_o.row  = tag_q.row;
  assign item_o.col  = tag_q.col;
  assign item_o.last = tag_q.last;

endmodule
`default_nettype wire

// File: design/bf3_out_fifo.sv
// Result FIFO in flops; head entry drives the output channel directly.
// Depends on bf3_pkg.
`default_nettype none
module bf3_out_fifo
  import bf3_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire out_item_t      item_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output out_item_t           item_o,
  output logic [FIFO_AW:0]    count_o
);

  out_item_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   count_q;
  logic               pop;

  assign valid_o = count_q != '0;
  assign pop     = valid_o && ready_i;
  assign item_o  = mem_q[rd_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + FIFO_AW'(1);
      if (pop)    rd_q <= rd_q + FIFO_AW'(1);
      count_q <= count_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// File: design/box_filter_3x3_stream.sv
// Top level of the streaming 3x3 mean filter: position counters, line store,
// window, divider and result FIFO. Depends on bf3_pkg and all bf3_* modules.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------
//  input    | in        | in_valid/in_ready    | sample
//  output   | out       | out_valid/out_ready  | average, out_row, out_col, frame_last
//  config   | in        | cfg_we (no wait)     | cfg_idx, cfg_data
//
// One sample per cycle while in_ready is high; a result passes through the line store
// read, window sum, reciprocal multiply and FIFO head, in that order.
// The line store is one 1024x32 RAM, read at accept, written back in the next cycle;
// the same entry is read again only a full row (3 samples or more) later.
// in_ready drops only when the 8-entry result FIFO plus results in flight is full.
// Reset clears counters and the window; line store contents are undefined.
`default_nettype none
module box_filter_3x3_stream
  import bf3_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [SAMPLE_BITS-1:0] average_o,
  output logic      [ROW_W-1:0]       out_row_o,
  output logic      [COL_W-1:0]       out_col_o,
  output logic                        frame_last_o
);

  logic [ROWS_W-1:0] rows_q;
  logic [COLS_W-1:0] cols_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;

  logic              accept;
  logic [ROWS_W-1:0] row_next;
  logic [COLS_W-1:0] col_next;
  logic [ROWS_W-1:0] rows_wr;
  logic [COLS_W-1:0] cols_wr;
  tag_t              tag_d;

  logic                   s1_valid_q;
  tag_t                   s1_tag_q;
  logic [ADDR_W-1:0]      s1_addr_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic [LINE_W-1:0]      line_rdata;
  logic [SAMPLE_BITS-1:0] top, mid;

  logic              s2_valid;
  tag_t              s2_tag;
  logic [SUM_W-1:0]  s2_sum;
  logic              s3_valid;
  out_item_t         s3_item;
  out_item_t         head;
  logic [FIFO_AW:0]  fifo_count;
  logic [FIFO_AW+1:0] occupied;

  assign occupied = (FIFO_AW+2)'(fifo_count) + (FIFO_AW+2)'(s1_valid_q && s1_tag_q.res)
                  + (FIFO_AW+2)'(s2_valid) + (FIFO_AW+2)'(s3_valid);
  assign in_ready_o = occupied < (FIFO_AW+2)'(FIFO_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  assign row_next = ROWS_W'(row_q) + ROWS_W'(1);
  assign col_next = COLS_W'(col_q) + COLS_W'(1);

  assign tag_d.res  = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
  assign tag_d.row  = row_q - ROW_W'(1);
  assign tag_d.col  = col_q - COL_W'(1);
  assign tag_d.last = (row_next == rows_q) && (col_next == cols_q);

  // register writes, clamped to the legal range (column value taken from the low 11 bits first)
  always_comb begin
    rows_wr = cfg_data_i;
    if (rows_wr < ROWS_MIN)   rows_wr = ROWS_MIN;
    if (rows_wr > ROWS_LIMIT) rows_wr = ROWS_LIMIT;
    cols_wr = cfg_data_i[COLS_W-1:0];
    if (cols_wr < COLS_MIN)   cols_wr = COLS_MIN;
    if (cols_wr > COLS_LIMIT) cols_wr = COLS_LIMIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= ROWS_LIMIT;
      cols_q     <= COLS_LIMIT;
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (cfg_we_i && (cfg_idx_i == REG_FRAME_ROWS || cfg_idx_i == REG_FRAME_COLS)) begin
        if (cfg_idx_i == REG_FRAME_ROWS) rows_q <= rows_wr;
        else                             cols_q <= cols_wr;
        row_q <= '0;
        col_q <= '0;
      end else if (accept) begin
        if (col_next >= cols_q) begin
          col_q <= '0;
          row_q <= (row_next >= rows_q) ? '0 : row_next[ROW_W-1:0];
        end else begin
          col_q <= col_next[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_tag_q    <= tag_d;
      s1_addr_q   <= col_q[ADDR_W-1:0];
      s1_sample_q <= sample_i;
    end
  end

  // entry holds {row r-2, row r-1}; written back as {row r-1, row r}
  bf3_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLS)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i ({mid, s1_sample_q}),
    .re_i    (accept),
    .raddr_i (col_q[ADDR_W-1:0]),
    .rdata_o (line_rdata)
  );

  assign top = line_rdata[LINE_W-1:SAMPLE_BITS];
  assign mid = line_rdata[SAMPLE_BITS-1:0];

  bf3_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .tag_i   (s1_tag_q),
    .top_i   (top),
    .mid_i   (mid),
    .bot_i   (s1_sample_q),
    .valid_o (s2_valid),
    .tag_o   (s2_tag),
    .sum_o   (s2_sum)
  );

  bf3_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .tag_i   (s2_tag),
    .sum_i   (s2_sum),
    .valid_o (s3_valid),
    .item_o  (s3_item)
  );

  bf3_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s3_valid),
    .item_i  (s3_item),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .item_o  (head),
    .count_o (fifo_count)
  );

  assign average_o    = head.avg;
  assign out_row_o    = head.row;
  assign out_col_o    = head.col;
  assign frame_last_o = head.last;

endmodule
`default_nettype wire
